FILE: rtl/ordered_list_insert_front_delete_value_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list core
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_FRONT_DELETE_VALUE_CORE_DEFINES_SVH
`define ORDERED_LIST_INSERT_FRONT_DELETE_VALUE_CORE_DEFINES_SVH

// Check a property at every rising edge outside reset
`define OLIFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define OLIFD_ASSERT_NEXT(label, pre, post, msg) \
   `OLIFD_ASSERT(label, (pre) |=> (post), msg)

`endif

FILE: rtl/olifd_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list core package
// Field widths, action and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package olifd_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   // Action codes carried on the request side
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   // Status codes returned with each result
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   // Control broadcast from the sequencer to every cell
   typedef struct packed {
      logic search;   // register the compare of each cell against the key
      logic ins;      // shift the whole row back one place, key enters at front
      logic del;      // cells at or behind the hit take their back neighbor
   } cell_ctrl_type;

endpackage

FILE: rtl/olifd_cell.sv
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one entry, compares it against the key and shifts with its neighbors.
// ----------------------------------------------------------------------------
module olifd_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  olifd_pkg::cell_ctrl_type         ctrl,
   input  logic [olifd_pkg::VALUE_W-1:0]    key,
   input  logic [olifd_pkg::VALUE_W-1:0]    prev_value,
   input  logic                             prev_valid,
   input  logic [olifd_pkg::VALUE_W-1:0]    next_value,
   input  logic                             next_valid,
   input  logic                             hit_in,
   output logic                             hit_out,
   output logic [olifd_pkg::VALUE_W-1:0]    value,
   output logic                             valid
);
   import olifd_pkg::*;

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;
   logic               valid_ff;
   logic               valid_in;
   logic               match_ff;
   logic               match_in;

   // Ripple the first-hit mark toward the back of the row
   assign hit_out = hit_in | match_ff;

   // Select next entry: take front neighbor on insert, back neighbor on delete
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      match_in = match_ff;
      if (ctrl.search) begin
         match_in = valid_ff && (value_ff == key);
      end
      if (ctrl.ins) begin
         value_in = prev_value;
         valid_in = prev_valid;
      end else if (ctrl.del && hit_out) begin
         value_in = next_value;
         valid_in = next_valid;
      end
   end

   // Hold control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

FILE: rtl/ordered_list_insert_front_delete_value_core.sv
// ----------------------------------------------------------------------------
// Ordered list core: insert at front, delete first entry by value
// Row of DEPTH cells holding a front-first list of 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_*: req_tuser[0] selects insert (0) or remove (1),
//   req_tdata carries the value to insert or to search for.
//   Result channel rsp_*: rsp_tuser gives the status (done, not found,
//   empty, full), rsp_tdata[4:0] the entry count after the item.
//   Every request gives exactly one result, in order.
// Sequence:
//   An item passes through capture, parallel compare in every cell, then
//   commit, where the first-hit mark ripples through the cell row and
//   all cells shift at once. The result is registered at the commit;
//   the next request is taken only once the item has committed.
// Reset:
//   Clears the count and all valid bits; the list is empty at once, with
//   no clearing pass. Stored values are left as they are.
// Backpressure:
//   A finished result waits in the output register; the next request is
//   still accepted and compared, and its commit waits until the pending
//   result transfer completes.
// ----------------------------------------------------------------------------
module ordered_list_insert_front_delete_value_core #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [olifd_pkg::VALUE_W-1:0]     req_tdata,   // [31:0] value
   input  logic [0:0]                        req_tuser,   // [0] action
   // Result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [4:0] count, [7:5] zero
   output logic [1:0]                        rsp_tuser    // [1:0] status
);
   import olifd_pkg::*;

`include "ordered_list_insert_front_delete_value_core_defines.svh"

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMMIT
   } state_type;

   state_type          state_ff, state_in;
   logic               action_ff, action_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff, status_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   cell_ctrl_type      ctrl;
   logic [VALUE_W-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]   cell_valid;
   logic [DEPTH:0]     hit;
   logic               found;
   logic               full;
   logic               empty;
   logic               commit_go;

   assign hit[0] = 1'b0;
   assign found  = hit[DEPTH];
   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);

   // Commit once the output register is free or being drained
   assign commit_go = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_tready);

   // Broadcast cell controls
   always_comb begin
      ctrl.search = (state_ff == ST_SEARCH);
      ctrl.ins    = commit_go && (action_ff == ACT_INSERT) && !full;
      ctrl.del    = commit_go && (action_ff == ACT_REMOVE) && found;
   end

   // Row of cells, front at index 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_W-1:0] prev_value;
      logic               prev_valid;
      logic [VALUE_W-1:0] next_value;
      logic               next_valid;

      if (i == 0) begin : g_front
         assign prev_value = key_ff;
         assign prev_valid = 1'b1;
      end else begin : g_mid_front
         assign prev_value = cell_value[i-1];
         assign prev_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_back
         assign next_value = '0;
         assign next_valid = 1'b0;
      end else begin : g_mid_back
         assign next_value = cell_value[i+1];
         assign next_valid = cell_valid[i+1];
      end

      olifd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .key        (key_ff),
         .prev_value (prev_value),
         .prev_valid (prev_valid),
         .next_value (next_value),
         .next_valid (next_valid),
         .hit_in     (hit[i]),
         .hit_out    (hit[i+1]),
         .value      (cell_value[i]),
         .valid      (cell_valid[i])
      );
   end

   // Sequence one item and build its result
   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      rsp_count_in = rsp_count_ff;

      // Drop the result once its transfer completes
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               action_in = req_tuser[0];
               key_in    = req_tdata;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_go) begin
               if (action_ff == ACT_INSERT) begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     status_in = STATUS_DONE;
                     count_in  = count_ff + CW'(1);
                  end
               end else if (empty) begin
                  status_in = STATUS_EMPTY;
               end else if (found) begin
                  status_in = STATUS_DONE;
                  count_in  = count_ff - CW'(1);
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
               rsp_count_in = COUNT_W'(count_in);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff    <= action_in;
      key_ff       <= key_in;
      status_ff    <= status_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff};

   // Count stays within the row
   `OLIFD_ASSERT(a_count_range, count_ff <= CW'(DEPTH), "count beyond depth")

   // Valid bits track the count
   `OLIFD_ASSERT(a_valid_count, $countones(cell_valid) == int'(count_ff), "valid bits off count")

   // Count moves by at most one per cycle
   `OLIFD_ASSERT_NEXT(a_count_step, 1'b1,
      count_ff == $past(count_ff) || count_ff == $past(count_ff) + CW'(1) ||
      count_ff + CW'(1) == $past(count_ff),
      "count jumped")

   // An accepted request closes the input until its commit
   `OLIFD_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "second item taken")

endmodule
